// ----- design/csim_pkg.sv -----
package csim_pkg;

  // element and accumulator widths
  localparam int ELEM_W = 16;
  localparam int SUM_W  = 48;
  localparam int ROOT_W = 24;
  localparam int FRAC_W = 15;

  // accumulator saturation limits
  localparam logic signed [SUM_W-1:0] DOT_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] DOT_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]        SQ_MAX  = {SUM_W{1'b1}};

  // result saturation values
  localparam logic signed [ELEM_W-1:0] SIM_MAX = 16'sh7FFF;
  localparam logic signed [ELEM_W-1:0] SIM_MIN = 16'sh8000;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;
  localparam int Q_CW    = 2;

  // one finished vector's sums
  typedef struct packed {
    logic signed [SUM_W-1:0] dot;
    logic [SUM_W-1:0]        sq_a;
    logic [SUM_W-1:0]        sq_b;
  } sums_t;

endpackage

// ----- design/cosine_similarity_fixed.sv -----
// Streaming cosine similarity of two Q1.15 vectors, one element pair per cycle while the queue is not full.
// Throughput: one request per cycle while the queue is not full; sums of a finished vector wait in a 2-entry queue.
// From the last request to the result: pop, 24 root steps, product, compare, 15 divide
// steps, output; the divide steps are skipped when the ratio saturates or a norm is zero.
// The back end takes one vector at a time; once the queue is full, input stalls until it pops.
// Reset (synchronous, active high) clears the running sums, the queue and the output valid.
module cosine_similarity_fixed (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic        s_tlast,   // last_elem
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] similarity
  output logic        m_tuser    // zero_norm
);

  logic            push_valid;
  csim_pkg::sums_t push_sums;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  csim_pkg::sums_t q_data;

  // accumulate element pairs
  csim_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .push_valid(push_valid),
    .push_sums (push_sums)
  );

  // finished sums waiting for the back end
  csim_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push_valid),
    .push_data(push_sums),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_data (q_data)
  );

  // roots, product and division
  csim_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ----- design/csim_front.sv -----
module csim_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [31:0]    s_tdata,   // [15:0] elem_a, [31:16] elem_b
  input  logic           s_tlast,   // last_elem
  input  logic           q_full,
  output logic           push_valid,
  output csim_pkg::sums_t push_sums
);

  logic signed [csim_pkg::SUM_W-1:0] dot_sum;
  logic [csim_pkg::SUM_W-1:0]        norm_a_sum;
  logic [csim_pkg::SUM_W-1:0]        norm_b_sum;

  logic signed [csim_pkg::ELEM_W-1:0] elem_a;
  logic signed [csim_pkg::ELEM_W-1:0] elem_b;
  logic signed [31:0]                 prod_ab;
  logic signed [31:0]                 prod_aa;
  logic signed [31:0]                 prod_bb;
  logic signed [csim_pkg::SUM_W:0]    dot_wide;
  logic [csim_pkg::SUM_W:0]           sqa_wide;
  logic [csim_pkg::SUM_W:0]           sqb_wide;
  csim_pkg::sums_t                    sums_next;
  logic                               accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  assign elem_a = s_tdata[15:0];
  assign elem_b = s_tdata[31:16];

  // products and saturating accumulation
  always_comb begin
    prod_ab  = elem_a * elem_b;
    prod_aa  = elem_a * elem_a;
    prod_bb  = elem_b * elem_b;
    dot_wide = {dot_sum[csim_pkg::SUM_W-1], dot_sum} + (csim_pkg::SUM_W+1)'(prod_ab);
    sqa_wide = {1'b0, norm_a_sum} + {17'd0, prod_aa[31:0]};
    sqb_wide = {1'b0, norm_b_sum} + {17'd0, prod_bb[31:0]};

    if (dot_wide[csim_pkg::SUM_W] != dot_wide[csim_pkg::SUM_W-1]) begin
      sums_next.dot = dot_wide[csim_pkg::SUM_W] ? csim_pkg::DOT_MIN : csim_pkg::DOT_MAX;
    end else begin
      sums_next.dot = dot_wide[csim_pkg::SUM_W-1:0];
    end
    sums_next.sq_a = sqa_wide[csim_pkg::SUM_W] ? csim_pkg::SQ_MAX
                                               : sqa_wide[csim_pkg::SUM_W-1:0];
    sums_next.sq_b = sqb_wide[csim_pkg::SUM_W] ? csim_pkg::SQ_MAX
                                               : sqb_wide[csim_pkg::SUM_W-1:0];
  end

  // hand the finished sums to the queue on the last request
  assign push_valid = accept && s_tlast;
  assign push_sums  = sums_next;

  // running sums, cleared after each vector
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum    <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        dot_sum    <= '0;
        norm_a_sum <= '0;
        norm_b_sum <= '0;
      end else begin
        dot_sum    <= sums_next.dot;
        norm_a_sum <= sums_next.sq_a;
        norm_b_sum <= sums_next.sq_b;
      end
    end
  end

endmodule

// ----- design/csim_queue.sv -----
module csim_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csim_pkg::sums_t push_data,
  output logic            full,
  output logic            valid,
  input  logic            pop,
  output csim_pkg::sums_t pop_data
);

  csim_pkg::sums_t             entries [csim_pkg::Q_DEPTH];
  logic [csim_pkg::Q_AW-1:0]   wr_ptr;
  logic [csim_pkg::Q_AW-1:0]   rd_ptr;
  logic [csim_pkg::Q_CW-1:0]   count;
  logic                        do_push;
  logic                        do_pop;

  assign full     = (count == csim_pkg::Q_CW'(csim_pkg::Q_DEPTH));
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= csim_pkg::Q_CW'(csim_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");
`endif

endmodule

// ----- design/csim_back.sv -----
module csim_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  csim_pkg::sums_t q_data,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,   // [15:0] similarity
  output logic            m_tuser    // zero_norm
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQRT,
    B_MUL,
    B_CMP,
    B_DIV,
    B_DONE
  } bstate_t;

  bstate_t state;

  logic                              neg;
  logic [csim_pkg::SUM_W-1:0]        mag;
  logic [csim_pkg::SUM_W-1:0]        va;
  logic [csim_pkg::SUM_W-1:0]        vb;
  logic [csim_pkg::SUM_W-1:0]        root_a;
  logic [csim_pkg::SUM_W-1:0]        root_b;
  logic [csim_pkg::SUM_W-1:0]        sq_bit;
  logic [csim_pkg::SUM_W-1:0]        den;
  logic [csim_pkg::SUM_W-1:0]        rem;
  logic [csim_pkg::FRAC_W-1:0]       quo;
  logic [3:0]                        cnt;
  logic signed [csim_pkg::ELEM_W-1:0] res_sim;
  logic                              res_zero;

  logic [csim_pkg::SUM_W-1:0]  try_a;
  logic [csim_pkg::SUM_W-1:0]  try_b;
  logic                        ge_a;
  logic                        ge_b;
  logic [csim_pkg::SUM_W:0]    rem2;
  logic [csim_pkg::SUM_W:0]    den_ext;
  logic                        ge_d;
  logic [csim_pkg::FRAC_W-1:0] quo_next;
  logic                        out_free;

  // one square root step per unit, one division step
  always_comb begin
    try_a    = root_a + sq_bit;
    try_b    = root_b + sq_bit;
    ge_a     = (va >= try_a);
    ge_b     = (vb >= try_b);
    rem2     = {rem, 1'b0};
    den_ext  = {1'b0, den};
    ge_d     = (rem2 >= den_ext);
    quo_next = {quo[csim_pkg::FRAC_W-2:0], ge_d};
  end

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign out_free = !m_tvalid || m_tready;

  // sequencer: roots, product, compare, long division unless the compare settles the result, output
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // the done state reloads the output itself
      if (m_tvalid && m_tready && state != B_DONE) m_tvalid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            neg    <= q_data.dot[csim_pkg::SUM_W-1];
            mag    <= q_data.dot[csim_pkg::SUM_W-1] ? 48'(-q_data.dot) : q_data.dot;
            va     <= q_data.sq_a;
            vb     <= q_data.sq_b;
            root_a <= '0;
            root_b <= '0;
            sq_bit <= {2'b01, {(csim_pkg::SUM_W-2){1'b0}}};
            state  <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (ge_a) begin
            va     <= va - try_a;
            root_a <= (root_a >> 1) + sq_bit;
          end else begin
            root_a <= root_a >> 1;
          end
          if (ge_b) begin
            vb     <= vb - try_b;
            root_b <= (root_b >> 1) + sq_bit;
          end else begin
            root_b <= root_b >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == csim_pkg::SUM_W'(1)) state <= B_MUL;
        end
        B_MUL: begin
          den   <= root_a[csim_pkg::ROOT_W-1:0] * root_b[csim_pkg::ROOT_W-1:0];
          state <= B_CMP;
        end
        B_CMP: begin
          if (den == '0) begin
            res_sim  <= '0;
            res_zero <= 1'b1;
            state    <= B_DONE;
          end else if (mag >= den) begin
            // ratio at or beyond one saturates
            res_sim  <= neg ? csim_pkg::SIM_MIN : csim_pkg::SIM_MAX;
            res_zero <= 1'b0;
            state    <= B_DONE;
          end else begin
            rem   <= mag;
            quo   <= '0;
            cnt   <= 4'(csim_pkg::FRAC_W - 1);
            state <= B_DIV;
          end
        end
        B_DIV: begin
          rem <= ge_d ? 48'(rem2 - den_ext) : rem2[csim_pkg::SUM_W-1:0];
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            res_sim  <= neg ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
            res_zero <= 1'b0;
            state    <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            m_tdata  <= res_sim;
            m_tuser  <= res_zero;
            m_tvalid <= 1'b1;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_rem_below: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (rem < den))
    else $error("division remainder not below denominator");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    (state == B_DONE && m_tvalid && !m_tready) |=> (state == B_DONE))
    else $error("result left done state while output was held");
`endif

endmodule
